### rtl/perm_enum_pkg.sv
// ----------------------------------------------------------------------------
// perm_enum_pkg
// shared constants and types of the permutation enumerator
// ----------------------------------------------------------------------------
package perm_enum_pkg;

    // default sizing
    localparam int MAX_MEMBERS_DEF  = 8;
    localparam int MEMBER_WIDTH_DEF = 8;

    // configuration port
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int COUNT_W    = 4;

    localparam logic [CFG_IDX_W-1:0] REG_MEMBER_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_MEMBERS = 2'd1;

    // register reset values
    localparam logic [COUNT_W-1:0]    MEMBER_COUNT_RST  = 4'd8;
    localparam logic [CFG_DATA_W-1:0] FIRST_MEMBERS_RST = 64'h0706050403020100;

    // per-cycle command to the level cells
    typedef struct packed {
        logic load_first;  // restart: every cell takes the first order
        logic step;        // advance: the chosen level swaps, deeper ones follow
    } cell_ctrl_t;

endpackage

### rtl/permutation_enumerator.sv
// ----------------------------------------------------------------------------
// permutation_enumerator
// hands out every ordering of n configured members, one per request item
// ----------------------------------------------------------------------------
// usage:
//   input channel s_valid / s_ready / s_restart: each item is one request;
//     restart high starts over and yields the first ordering
//   result channel m_valid / m_ready / m_permutation / m_last: one item per
//     request, member at position k in bits k*MEMBER_WIDTH and up, positions
//     n and above zero; m_last marks the final one of the n! orderings
//   configuration: cfg_wr_en with cfg_index and cfg_wdata, taken at once;
//     index 0 is the member count, index 1 the first order; either write
//     makes the next request start over, other indexes are ignored
//   timing: one request per cycle while m_ready keeps the output moving, the
//     result sits in the output register in the cycle after its request is
//     taken; the step logic is one pass through the row of level cells
//   stall: s_ready is high while the output register is empty or is being
//     emptied, so a held m_ready holds requests back and nothing is lost
//   reset: member count 8, first order 0..7, not running, output empty
// ----------------------------------------------------------------------------
module permutation_enumerator #(
    parameter int MAX_MEMBERS  = perm_enum_pkg::MAX_MEMBERS_DEF,
    parameter int MEMBER_WIDTH = perm_enum_pkg::MEMBER_WIDTH_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // configuration
    input  logic                                   cfg_wr_en,
    input  logic [perm_enum_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [perm_enum_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    // request items
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic                                   s_restart,
    // result items
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [MAX_MEMBERS*MEMBER_WIDTH-1:0]    m_permutation,
    output logic                                   m_last
);
    import perm_enum_pkg::*;

    localparam int ORDER_W = MAX_MEMBERS * MEMBER_WIDTH;
    localparam int LEVELS  = MAX_MEMBERS - 2;

    // configuration registers
    logic [COUNT_W-1:0] n_reg;
    logic [ORDER_W-1:0] first_reg;

    // enumeration control state
    logic running_reg, running_next;
    logic second_half_reg, second_half_next;
    logic [ORDER_W-1:0] current_reg, current_next;

    // output register
    logic               m_valid_reg, m_valid_next;
    logic [ORDER_W-1:0] m_perm_reg, m_perm_next;
    logic               m_last_reg, m_last_next;

    logic               accept;
    logic [COUNT_W-1:0] n_use;
    logic [ORDER_W-1:0] first_order;   // first members, unused positions zeroed
    logic [ORDER_W-1:0] tail_swapped;  // current order with last two swapped
    logic               do_begin;
    cell_ctrl_t         ctrl;

    // level chain: found runs deep to shallow, new block start shallow to deep
    logic               found_chain [LEVELS+1];
    logic               hit_chain   [LEVELS+1];
    logic [ORDER_W-1:0] order_chain [LEVELS+1];

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    assign m_valid       = m_valid_reg;
    assign m_permutation = m_perm_reg;
    assign m_last        = m_last_reg;

    // member count clamped to 1..MAX_MEMBERS
    always_comb begin
        if (n_reg == '0) begin
            n_use = COUNT_W'(1);
        end else if (n_reg > COUNT_W'(MAX_MEMBERS)) begin
            n_use = COUNT_W'(MAX_MEMBERS);
        end else begin
            n_use = n_reg;
        end
    end

    // first order and tail swap, one member lane at a time
    always_comb begin
        logic [ORDER_W-1:0] nxt_sh, prv_sh;
        for (int p = 0; p < MAX_MEMBERS; p++) begin
            first_order[p*MEMBER_WIDTH +: MEMBER_WIDTH] = (COUNT_W'(p) < n_use) ?
                first_reg[p*MEMBER_WIDTH +: MEMBER_WIDTH] : '0;
            nxt_sh = current_reg >> ((p + 1) * MEMBER_WIDTH);
            prv_sh = ORDER_W'(current_reg << MEMBER_WIDTH) >> (p * MEMBER_WIDTH);
            if (COUNT_W'(p + 2) == n_use) begin
                tail_swapped[p*MEMBER_WIDTH +: MEMBER_WIDTH] = nxt_sh[MEMBER_WIDTH-1:0];
            end else if (COUNT_W'(p + 1) == n_use) begin
                tail_swapped[p*MEMBER_WIDTH +: MEMBER_WIDTH] = prv_sh[MEMBER_WIDTH-1:0];
            end else begin
                tail_swapped[p*MEMBER_WIDTH +: MEMBER_WIDTH] =
                    current_reg[p*MEMBER_WIDTH +: MEMBER_WIDTH];
            end
        end
    end

    // row of level cells
    assign found_chain[LEVELS] = 1'b0;
    assign hit_chain[0]        = 1'b0;
    assign order_chain[0]      = '0;

    for (genvar l = 0; l < LEVELS; l++) begin : g_level
        perm_enum_cell #(
            .MAX_MEMBERS  (MAX_MEMBERS),
            .MEMBER_WIDTH (MEMBER_WIDTH),
            .LEVEL        (l)
        ) u_cell (
            .aclk         (aclk),
            .aresetn      (aresetn),
            .ctrl         (ctrl),
            .n_use        (n_use),
            .first_order  (first_order),
            .deeper_found (found_chain[l+1]),
            .found_out    (found_chain[l]),
            .hit_in       (hit_chain[l]),
            .order_in     (order_chain[l]),
            .hit_out      (hit_chain[l+1]),
            .order_out    (order_chain[l+1])
        );
    end

    // restart when asked, when idle, or when no level can advance
    always_comb begin
        if (s_restart || !running_reg) begin
            do_begin = 1'b1;
        end else if (second_half_reg) begin
            do_begin = n_use < COUNT_W'(2);
        end else begin
            do_begin = (n_use < COUNT_W'(3)) || !hit_chain[LEVELS];
        end
    end

    assign ctrl.load_first = accept && do_begin;
    assign ctrl.step       = accept && !do_begin && !second_half_reg;

    always_comb begin
        running_next     = running_reg;
        second_half_next = second_half_reg;
        current_next     = current_reg;
        m_valid_next     = m_valid_reg;
        m_perm_next      = m_perm_reg;
        m_last_next      = m_last_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (accept) begin
            m_valid_next = 1'b1;
            if (do_begin) begin
                // first order; a single member is already the last one
                current_next     = first_order;
                m_perm_next      = first_order;
                m_last_next      = n_use == COUNT_W'(1);
                second_half_next = n_use != COUNT_W'(1);
                running_next     = n_use != COUNT_W'(1);
            end else if (second_half_reg) begin
                // partner of the pair; last when no level can advance
                m_perm_next      = tail_swapped;
                m_last_next      = !found_chain[0];
                second_half_next = 1'b0;
                running_next     = found_chain[0];
            end else begin
                // new block start from the deepest free level
                current_next     = order_chain[LEVELS];
                m_perm_next      = order_chain[LEVELS];
                m_last_next      = 1'b0;
                second_half_next = 1'b1;
            end
        end

        // any register write starts the enumeration over
        if (cfg_wr_en && (cfg_index inside {REG_MEMBER_COUNT, REG_FIRST_MEMBERS})) begin
            running_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_reg     <= MEMBER_COUNT_RST;
            first_reg <= ORDER_W'(FIRST_MEMBERS_RST);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_MEMBER_COUNT: begin
                    n_reg <= cfg_wdata[COUNT_W-1:0];
                end
                REG_FIRST_MEMBERS: begin
                    first_reg <= cfg_wdata[ORDER_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_reg     <= 1'b0;
            second_half_reg <= 1'b0;
            current_reg     <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            running_reg     <= running_next;
            second_half_reg <= second_half_next;
            current_reg     <= current_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_perm_reg <= m_perm_next;
        m_last_reg <= m_last_next;
    end

endmodule

### rtl/perm_enum_cell.sv
// ----------------------------------------------------------------------------
// perm_enum_cell
// one level of the enumerator: a counter and the order that started its block
// ----------------------------------------------------------------------------
module perm_enum_cell #(
    parameter int MAX_MEMBERS  = perm_enum_pkg::MAX_MEMBERS_DEF,
    parameter int MEMBER_WIDTH = perm_enum_pkg::MEMBER_WIDTH_DEF,
    parameter int LEVEL        = 0
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  perm_enum_pkg::cell_ctrl_t             ctrl,
    input  logic [perm_enum_pkg::COUNT_W-1:0]     n_use,
    input  logic [MAX_MEMBERS*MEMBER_WIDTH-1:0]   first_order,
    input  logic                                  deeper_found,
    output logic                                  found_out,
    input  logic                                  hit_in,
    input  logic [MAX_MEMBERS*MEMBER_WIDTH-1:0]   order_in,
    output logic                                  hit_out,
    output logic [MAX_MEMBERS*MEMBER_WIDTH-1:0]   order_out
);
    import perm_enum_pkg::*;

    localparam int ORDER_W = MAX_MEMBERS * MEMBER_WIDTH;
    localparam int CNT_W   = $clog2(MAX_MEMBERS);

    logic [CNT_W-1:0]   counter_reg, counter_next;
    logic [ORDER_W-1:0] block_reg, block_next;
    logic [COUNT_W-1:0] cnt_ext;
    logic               level_used, active, selected;
    logic [CNT_W-1:0]   swap_pos;
    logic [MEMBER_WIDTH-1:0] at_level, at_swap;
    logic [ORDER_W-1:0] swapped;

    assign cnt_ext    = COUNT_W'(counter_reg);
    assign level_used = (LEVEL + 3) <= int'(n_use);
    assign active     = level_used && ((cnt_ext + COUNT_W'(1)) < n_use);
    assign selected   = active && !deeper_found;
    assign found_out  = active || deeper_found;
    assign swap_pos   = counter_reg + CNT_W'(1);

    assign at_level = block_reg[LEVEL*MEMBER_WIDTH +: MEMBER_WIDTH];
    assign at_swap  = block_reg[swap_pos*MEMBER_WIDTH +: MEMBER_WIDTH];

    always_comb begin
        for (int p = 0; p < MAX_MEMBERS; p++) begin
            if (p == LEVEL) begin
                swapped[p*MEMBER_WIDTH +: MEMBER_WIDTH] = at_swap;
            end else if (CNT_W'(p) == swap_pos) begin
                swapped[p*MEMBER_WIDTH +: MEMBER_WIDTH] = at_level;
            end else begin
                swapped[p*MEMBER_WIDTH +: MEMBER_WIDTH] =
                    block_reg[p*MEMBER_WIDTH +: MEMBER_WIDTH];
            end
        end
    end

    // new block start travels toward deeper levels
    assign order_out = selected ? swapped : order_in;
    assign hit_out   = selected || hit_in;

    always_comb begin
        counter_next = counter_reg;
        block_next   = block_reg;
        if (ctrl.load_first) begin
            counter_next = CNT_W'(LEVEL);
            block_next   = first_order;
        end else if (ctrl.step && (selected || hit_in)) begin
            counter_next = selected ? swap_pos : CNT_W'(LEVEL);
            block_next   = order_out;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            counter_reg <= CNT_W'(LEVEL);
        end else begin
            counter_reg <= counter_next;
        end
    end

    always_ff @(posedge aclk) begin
        block_reg <= block_next;
    end

endmodule
